// File: rtl/pbth_pkg.sv
// ----------------------------------------------------------------------------
// pbth_pkg
// Shared constants, types and helper functions of the per-bunch trigger
// histogram.
// ----------------------------------------------------------------------------
package pbth_pkg;

	localparam int NUM_BUNCHES = 3564;
	localparam int COUNT_BITS  = 32;

	localparam int BUNCH_AW = (NUM_BUNCHES > 1) ? $clog2(NUM_BUNCHES) : 1;
	localparam int IDX_W    = $clog2(NUM_BUNCHES + 1);

	localparam int SEL_W    = 7;
	localparam int WFR_W    = 10;
	localparam int OPF_W    = 9;
	localparam int CFG_W    = 10;
	localparam int CFG_IDXW = 2;
	localparam int WORB_W   = 18;
	localparam int SUM_W    = 48;
	localparam int ORB_W    = 32;
	localparam int RD_W     = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDXW-1:0] REG_SEL_A = 2'd0;
	localparam logic [CFG_IDXW-1:0] REG_SEL_B = 2'd1;
	localparam logic [CFG_IDXW-1:0] REG_WFR   = 2'd2;
	localparam logic [CFG_IDXW-1:0] REG_OPF   = 2'd3;

	// Operation codes of an input beat.
	localparam logic [2:0] OP_RECORD = 3'd0;
	localparam logic [2:0] OP_EOF    = 3'd1;
	localparam logic [2:0] OP_FILL   = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_FLUSH  = 3'd4;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	typedef enum logic [2:0] {
		CMD_NOP, CMD_COUNT, CMD_DROP, CMD_EOF, CMD_FILL, CMD_READ, CMD_FLUSH
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_INC, ST_READ, ST_WALK, ST_EMIT
	} state_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [11:0]       bunch;
		logic              in_range;
		logic              hit_a;
		logic              hit_b;
		logic              filled_flag;
		logic [ORB_W-1:0]  first;
	} item_t;

	typedef struct packed {
		logic [WFR_W-1:0] window_frames;
		logic [OPF_W-1:0] orbits_per_frame;
	} back_cfg_t;

	function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [SUM_W-1:0] sum_inc(input logic [SUM_W-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] a,
			input logic [COUNT_BITS-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W + 1)'(b);
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	function automatic logic [RD_W-1:0] clamp32(input logic [COUNT_BITS-1:0] v);
		logic [SUM_W-1:0] e;
		e = SUM_W'(v);
		return (e > SUM_W'(48'hFFFF_FFFF)) ? '1 : e[RD_W-1:0];
	endfunction

endpackage

// File: rtl/pbth_in_if.sv
// ----------------------------------------------------------------------------
// pbth_in_if
// Input channel: valid/ready handshake with one trigger item per beat.
// ----------------------------------------------------------------------------
interface pbth_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [31:0] record_orbit;
	logic [11:0] bunch;
	logic [63:0] trigger_mask;
	logic [31:0] frame_first_orbit;
	logic        filled_flag;

	modport source (output valid, op, record_orbit, bunch, trigger_mask,
		frame_first_orbit, filled_flag, input ready);
	modport sink (input valid, op, record_orbit, bunch, trigger_mask,
		frame_first_orbit, filled_flag, output ready);
endinterface

// File: rtl/pbth_out_if.sv
// ----------------------------------------------------------------------------
// pbth_out_if
// Output channel: valid/ready handshake with one summary or readout per beat.
// ----------------------------------------------------------------------------
interface pbth_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [17:0] window_orbit_count;
	logic [31:0] window_start;
	logic [47:0] filled_sum_a;
	logic [47:0] filled_sum_b;
	logic [47:0] fill_total_a;
	logic [47:0] fill_total_b;
	logic [31:0] dropped_records;
	logic [31:0] bunch_count_a;
	logic [31:0] bunch_count_b;

	modport source (output valid, kind, window_orbit_count, window_start,
		filled_sum_a, filled_sum_b, fill_total_a, fill_total_b, dropped_records,
		bunch_count_a, bunch_count_b, input ready);
	modport sink (input valid, kind, window_orbit_count, window_start,
		filled_sum_a, filled_sum_b, fill_total_a, fill_total_b, dropped_records,
		bunch_count_a, bunch_count_b, output ready);
endinterface

// File: rtl/pbth_ram.sv
// ----------------------------------------------------------------------------
// pbth_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// File: rtl/pbth_front.sv
// ----------------------------------------------------------------------------
// pbth_front
// Holds the configuration registers, accepts input beats and classifies them
// into commands for the back end.
// ----------------------------------------------------------------------------
module pbth_front (
	input  logic                              clk,
	input  logic                              arst_n,
	pbth_in_if.sink                           in_ch,
	input  logic                              cfg_we,
	input  logic [pbth_pkg::CFG_IDXW-1:0]     cfg_index,
	input  logic [pbth_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              q_ready,
	output logic                              q_push,
	output pbth_pkg::item_t                   q_item,
	output pbth_pkg::back_cfg_t               back_cfg
);
	import pbth_pkg::*;

	logic [SEL_W-1:0] sel_a_q, sel_b_q;
	logic [WFR_W-1:0] wfr_q;
	logic [OPF_W-1:0] opf_q;
	logic [ORB_W:0]   upper;
	logic             in_frame;
	logic [SEL_W-1:0] sel_a_m1, sel_b_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_a_q <= SEL_W'(1);
			sel_b_q <= SEL_W'(2);
			wfr_q   <= WFR_W'(100);
			opf_q   <= OPF_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEL_A: sel_a_q <= cfg_data[SEL_W-1:0];
				REG_SEL_B: sel_b_q <= cfg_data[SEL_W-1:0];
				REG_WFR:   wfr_q   <= cfg_data[WFR_W-1:0];
				REG_OPF:   opf_q   <= cfg_data[OPF_W-1:0];
			endcase
		end
	end

	assign back_cfg.window_frames    = wfr_q;
	assign back_cfg.orbits_per_frame = opf_q;

	assign in_ch.ready = q_ready;
	assign q_push      = in_ch.valid && q_ready;

	// The upper bound is formed one bit wider so that it never wraps.
	assign upper    = {1'b0, in_ch.frame_first_orbit} + (ORB_W + 1)'(opf_q);
	assign in_frame = (in_ch.record_orbit >= in_ch.frame_first_orbit) &&
		({1'b0, in_ch.record_orbit} < upper);
	assign sel_a_m1 = sel_a_q - 1'b1;
	assign sel_b_m1 = sel_b_q - 1'b1;

	always_comb begin
		q_item.bunch       = in_ch.bunch;
		q_item.in_range    = (13'(in_ch.bunch) < 13'(NUM_BUNCHES));
		q_item.hit_a       = (sel_a_q != '0) && (sel_a_q <= SEL_W'(64)) &&
			in_ch.trigger_mask[sel_a_m1[5:0]];
		q_item.hit_b       = (sel_b_q != '0) && (sel_b_q <= SEL_W'(64)) &&
			in_ch.trigger_mask[sel_b_m1[5:0]];
		q_item.filled_flag = in_ch.filled_flag;
		q_item.first       = in_ch.frame_first_orbit;
		unique case (in_ch.op)
			OP_RECORD: q_item.cmd = in_frame ? CMD_COUNT : CMD_DROP;
			OP_EOF:    q_item.cmd = CMD_EOF;
			OP_FILL:   q_item.cmd = CMD_FILL;
			OP_READ:   q_item.cmd = CMD_READ;
			OP_FLUSH:  q_item.cmd = CMD_FLUSH;
			default:   q_item.cmd = CMD_NOP;
		endcase
	end
endmodule

// File: rtl/pbth_queue.sv
// ----------------------------------------------------------------------------
// pbth_queue
// Two-entry queue of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module pbth_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pbth_pkg::item_t push_item,
	output logic            ready,
	input  logic            pop,
	output logic            valid,
	output pbth_pkg::item_t head
);
	import pbth_pkg::*;

	item_t      slot_q [2];
	logic       rd_ptr_q, wr_ptr_q;
	logic [1:0] count_q;

	assign ready = (count_q != 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0) else $error("queue popped while empty");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !pop) |=> count_q == 2'd2)
		else $error("queue lost an entry while full");
endmodule

// File: rtl/pbth_back.sv
// ----------------------------------------------------------------------------
// pbth_back
// Executes commands: per-bunch counting in the active banks, filled map
// writes, readouts, and the window close that walks the banks.
// ----------------------------------------------------------------------------
module pbth_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pbth_pkg::back_cfg_t cfg,
	input  logic                q_valid,
	input  pbth_pkg::item_t     q_head,
	output logic                q_pop,
	pbth_out_if.source          out_ch
);
	import pbth_pkg::*;

	state_t state_q, state_nx;
	item_t  cur_q;

	logic [IDX_W-1:0]      idx_q;
	logic                  walk_vld_s1;
	logic [BUNCH_AW-1:0]   walk_addr_s1;
	logic [WFR_W-1:0]      frames_q;
	logic [WORB_W-1:0]     orbits_q;
	logic [ORB_W-1:0]      start_q;
	logic [SUM_W-1:0]      total_a_q, total_b_q, sum_a_q, sum_b_q;
	logic [ORB_W-1:0]      drop_q;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  out_load;

	logic [WFR_W-1:0]      frames_inc;
	logic [WORB_W:0]       orbits_add;
	logic                  eof_close;
	logic [BUNCH_AW-1:0]   head_addr, cur_addr, idx_addr;

	logic                  act_re, act_we, cls_re, cls_we, fil_re, fil_we;
	logic [BUNCH_AW-1:0]   act_raddr, act_waddr, cls_raddr, cls_waddr;
	logic [BUNCH_AW-1:0]   fil_raddr, fil_waddr;
	logic [COUNT_BITS-1:0] act_a_wd, act_b_wd, cls_a_wd, cls_b_wd;
	logic [COUNT_BITS-1:0] act_a_rd, act_b_rd, cls_a_rd, cls_b_rd;
	logic                  fil_wd, fil_rd;

	assign out_free   = !out_valid_q || out_ch.ready;
	assign out_load   = ((state_q == ST_READ) || (state_q == ST_EMIT)) && out_free;
	assign head_addr  = q_head.bunch[BUNCH_AW-1:0];
	assign cur_addr   = cur_q.bunch[BUNCH_AW-1:0];
	assign idx_addr   = idx_q[BUNCH_AW-1:0];
	assign frames_inc = frames_q + 1'b1;
	assign orbits_add = {1'b0, orbits_q} + (WORB_W + 1)'(cfg.orbits_per_frame);
	assign eof_close  = (frames_inc >= cfg.window_frames);
	assign q_pop      = (state_q == ST_IDLE) && q_valid;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: if (idx_q == IDX_W'(NUM_BUNCHES - 1)) state_nx = ST_IDLE;
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_head.cmd)
						CMD_COUNT: if (q_head.in_range) state_nx = ST_INC;
						CMD_READ:  state_nx = ST_READ;
						CMD_EOF:   if (eof_close) state_nx = ST_WALK;
						CMD_FLUSH: if (frames_q != '0) state_nx = ST_WALK;
						default:   state_nx = ST_IDLE;
					endcase
				end
			end
			ST_INC:  state_nx = ST_IDLE;
			ST_READ: if (out_free) state_nx = ST_IDLE;
			ST_WALK: if (idx_q == IDX_W'(NUM_BUNCHES)) state_nx = ST_EMIT;
			ST_EMIT: if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		act_re = 1'b0; act_we = 1'b0; cls_re = 1'b0; cls_we = 1'b0;
		fil_re = 1'b0; fil_we = 1'b0;
		act_raddr = head_addr; act_waddr = cur_addr;
		cls_raddr = head_addr; cls_waddr = walk_addr_s1;
		fil_raddr = idx_addr;  fil_waddr = head_addr;
		act_a_wd = '0; act_b_wd = '0; cls_a_wd = act_a_rd; cls_b_wd = act_b_rd;
		fil_wd = q_head.filled_flag;
		unique case (state_q)
			ST_CLEAR: begin
				act_we = 1'b1; cls_we = 1'b1; fil_we = 1'b1;
				act_waddr = idx_addr; cls_waddr = idx_addr; fil_waddr = idx_addr;
				cls_a_wd = '0; cls_b_wd = '0; fil_wd = 1'b0;
			end
			ST_IDLE: begin
				if (q_valid && q_head.in_range) begin
					act_re = (q_head.cmd == CMD_COUNT);
					cls_re = (q_head.cmd == CMD_READ);
					fil_we = (q_head.cmd == CMD_FILL);
				end
			end
			ST_INC: begin
				act_we   = 1'b1;
				act_a_wd = cur_q.hit_a ? cnt_inc(act_a_rd) : act_a_rd;
				act_b_wd = cur_q.hit_b ? cnt_inc(act_b_rd) : act_b_rd;
			end
			ST_WALK: begin
				act_re    = (idx_q < IDX_W'(NUM_BUNCHES));
				fil_re    = act_re;
				act_raddr = idx_addr;
				act_we    = walk_vld_s1;
				act_waddr = walk_addr_s1;
				cls_we    = walk_vld_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			walk_vld_s1 <= 1'b0;
			frames_q    <= '0;
			orbits_q    <= '0;
			start_q     <= '0;
			total_a_q   <= '0;
			total_b_q   <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			walk_vld_s1 <= (state_q == ST_WALK) && act_re;
			out_valid_q <= out_load || (out_valid_q && !out_ch.ready);
			unique case (state_q)
				ST_CLEAR: idx_q <= idx_q + 1'b1;
				ST_IDLE: begin
					idx_q <= '0;
					if (q_valid) begin
						unique case (q_head.cmd)
							CMD_DROP: if (!(&drop_q)) drop_q <= drop_q + 1'b1;
							CMD_EOF: begin
								if (frames_q == '0) begin
									start_q <= q_head.first;
								end
								orbits_q <= orbits_add[WORB_W] ? '1 : orbits_add[WORB_W-1:0];
								frames_q <= frames_inc;
							end
							default: begin
							end
						endcase
					end
				end
				ST_INC: begin
					if (cur_q.hit_a) total_a_q <= sum_inc(total_a_q);
					if (cur_q.hit_b) total_b_q <= sum_inc(total_b_q);
				end
				ST_WALK: if (idx_q < IDX_W'(NUM_BUNCHES)) idx_q <= idx_q + 1'b1;
				ST_EMIT: begin
					if (out_free) begin
						frames_q <= '0;
						orbits_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		walk_addr_s1 <= idx_addr;
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (state_q == ST_IDLE) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (state_q == ST_WALK && walk_vld_s1 && fil_rd) begin
			sum_a_q <= sum_add(sum_a_q, act_a_rd);
			sum_b_q <= sum_add(sum_b_q, act_b_rd);
		end
		if (state_q == ST_READ && out_free) begin
			out_ch.kind               <= KIND_READOUT;
			out_ch.window_orbit_count <= '0;
			out_ch.window_start       <= '0;
			out_ch.filled_sum_a       <= '0;
			out_ch.filled_sum_b       <= '0;
			out_ch.fill_total_a       <= '0;
			out_ch.fill_total_b       <= '0;
			out_ch.dropped_records    <= '0;
			out_ch.bunch_count_a      <= cur_q.in_range ? clamp32(cls_a_rd) : '0;
			out_ch.bunch_count_b      <= cur_q.in_range ? clamp32(cls_b_rd) : '0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_ch.kind               <= KIND_SUMMARY;
			out_ch.window_orbit_count <= orbits_q;
			out_ch.window_start       <= start_q;
			out_ch.filled_sum_a       <= sum_a_q;
			out_ch.filled_sum_b       <= sum_b_q;
			out_ch.fill_total_a       <= total_a_q;
			out_ch.fill_total_b       <= total_b_q;
			out_ch.dropped_records    <= drop_q;
			out_ch.bunch_count_a      <= '0;
			out_ch.bunch_count_b      <= '0;
		end
	end

	assign out_ch.valid = out_valid_q;

	pbth_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BUNCHES)) u_act_a (
		.clk, .we(act_we), .wr_addr(act_waddr), .wr_data(act_a_wd),
		.rd_en(act_re), .rd_addr(act_raddr), .rd_data(act_a_rd));
	pbth_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BUNCHES)) u_act_b (
		.clk, .we(act_we), .wr_addr(act_waddr), .wr_data(act_b_wd),
		.rd_en(act_re), .rd_addr(act_raddr), .rd_data(act_b_rd));
	pbth_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BUNCHES)) u_cls_a (
		.clk, .we(cls_we), .wr_addr(cls_waddr), .wr_data(cls_a_wd),
		.rd_en(cls_re), .rd_addr(cls_raddr), .rd_data(cls_a_rd));
	pbth_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_BUNCHES)) u_cls_b (
		.clk, .we(cls_we), .wr_addr(cls_waddr), .wr_data(cls_b_wd),
		.rd_en(cls_re), .rd_addr(cls_raddr), .rd_data(cls_b_rd));
	pbth_ram #(.WIDTH(1), .DEPTH(NUM_BUNCHES)) u_filled (
		.clk, .we(fil_we), .wr_addr(fil_waddr), .wr_data(fil_wd),
		.rd_en(fil_re), .rd_addr(fil_raddr), .rd_data(fil_rd));

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && idx_q == IDX_W'(NUM_BUNCHES)) |=> state_q == ST_EMIT)
		else $error("bank walk did not end in the summary state");
	a_inc_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INC |-> $past(q_pop) && $past(state_q) == ST_IDLE)
		else $error("counter update without a popped record");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_EMIT))
		else $error("result raised outside readout or summary");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_CLEAR) |-> !q_pop)
		else $error("command taken while the banks are being walked");
endmodule

// File: rtl/per_bunch_trigger_histogram_unit.sv
// ----------------------------------------------------------------------------
// per_bunch_trigger_histogram_unit
// Per-bunch trigger counting for two selected inputs with windowed readout.
// ----------------------------------------------------------------------------
// After reset the unit clears all NUM_BUNCHES (3564) entries of its bunch
// banks; meanwhile the queue takes at most two input beats, and no further
// beat is accepted until that pass is done. A front end classifies each
// beat and places it in a two-entry queue; the back end executes one
// command at a time. A counted record in range is a read-modify-write of
// the active bank RAMs, written back in ST_INC; a readout waits in ST_READ
// for a free output register; other commands are done in the idle state,
// and one that closes the window walks the banks one bunch per cycle, then
// emits the summary, and input stalls behind the queue meanwhile.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the unit is idle; the unit does not enforce it.
module per_bunch_trigger_histogram_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	pbth_in_if.sink                       in_ch,
	pbth_out_if.source                    out_ch,
	input  logic                          cfg_we,
	input  logic [pbth_pkg::CFG_IDXW-1:0] cfg_index,
	input  logic [pbth_pkg::CFG_W-1:0]    cfg_data
);
	import pbth_pkg::*;

	logic      q_push, q_ready, q_pop, q_valid;
	item_t     q_item, q_head;
	back_cfg_t back_cfg;

	pbth_front u_front (
		.clk, .arst_n, .in_ch, .cfg_we, .cfg_index, .cfg_data,
		.q_ready, .q_push, .q_item, .back_cfg);

	pbth_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_item(q_item), .ready(q_ready),
		.pop(q_pop), .valid(q_valid), .head(q_head));

	pbth_back u_back (
		.clk, .arst_n, .cfg(back_cfg), .q_valid, .q_head, .q_pop, .out_ch);
endmodule
